[src/gspe_pkg.sv]
// Shared constants, types and command/status structs for the shortest path engine.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none
package gspe_pkg;
  localparam int MaxNodes   = 64;
  localparam int NodeBits   = $clog2(MaxNodes);
  localparam int SlotBits   = 2 * NodeBits;
  localparam int WeightBits = 16;
  localparam int DistBits   = 22;
  localparam logic [DistBits-1:0] DistMax = {DistBits{1'b1}};

  localparam logic [2:0] OP_NEW    = 3'd0;
  localparam logic [2:0] OP_CREATE = 3'd1;
  localparam logic [2:0] OP_EDGE   = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_QUERY  = 3'd4;

  typedef logic [NodeBits-1:0] node_t;
  typedef logic [DistBits-1:0] dist_t;

  // commands from controller to datapath
  typedef struct packed {
    logic  load;       // capture input item
    logic  new_graph;  // apply node_count to presence map
    logic  set_pres;   // set presence of node_a
    logic  clr_pres;   // clear presence of node_a
    logic  clr_row;    // clear valid of edge (node_a, idx)
    logic  clr_col;    // clear valid of edge (idx, node_a)
    logic  clr_all;    // clear valid of edges (row_idx, idx)
    logic  edge_wr;    // write edge (node_a, node_b)
    logic  q_init;     // init scratch for query
    logic  relax_rd;   // issue edge and distance read (u, idx); relax follows in the next cycle
    logic  scan;       // issue distance read at idx; compare follows in the next cycle
    logic  scan_clr;   // reset scan result
    logic  settle;     // u <- best, du <- distance of best
    logic  res_rd;     // read distance of node_b for the result
    logic  idx_clr;
    logic  idx_inc;
    logic  row_inc;
    logic  finish;     // form result
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       a_live;
    logic       b_live;
    logic       a_in;    // node_a in range
    logic       idx_last;
    logic       row_last;
    logic       found;
  } stat_t;
endpackage
`default_nettype wire

[src/gspe_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module gspe_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[src/gspe_datapath.sv]
// Datapath: presence map, edge valid/cost memory, query scratch and relax/scan logic.
// Depends on gspe_pkg and gspe_ram.
`default_nettype none
module gspe_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire gspe_pkg::cmd_t       cmd,
  output gspe_pkg::stat_t           stat,
  input  wire logic [2:0]           op_in,
  input  wire logic [5:0]           node_a_in,
  input  wire logic [5:0]           node_b_in,
  input  wire logic [15:0]          weight_in,
  input  wire logic [6:0]           count_in,
  output logic [gspe_pkg::DistBits-1:0] res_dist,
  output logic                      res_reach
);
  import gspe_pkg::*;

  logic [2:0]  op_r;
  logic [5:0]  a_r, b_r;
  logic [WeightBits-1:0] w_r;
  logic [6:0]  cnt_r;
  logic [MaxNodes-1:0] pres_r, vis_r, reach_r;
  node_t idx_r, row_r, u_r, best_r, idx_d_r;
  logic  found_r;
  dist_t du_r, best_d_r;
  logic  rd_v_r, sc_v_r;

  // edge storage: valid and cost in one word, valid bits in RAM are cleared by sweeps
  logic                      e_we;
  logic [SlotBits-1:0]       e_waddr, e_raddr;
  logic [WeightBits:0]       e_wdata, e_rdata;

  gspe_ram #(.Width(WeightBits + 1), .Depth(MaxNodes * MaxNodes)) u_edge (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  // tentative distances; only entries whose reach bit is set are used
  logic  t_we;
  node_t t_waddr, t_raddr;
  dist_t t_wdata, t_rdata;

  gspe_ram #(.Width(DistBits), .Depth(MaxNodes)) u_dist (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  node_t a_n, b_n;
  assign a_n = a_r[NodeBits-1:0];
  assign b_n = b_r[NodeBits-1:0];

  always_comb begin
    e_we    = 1'b0;
    e_waddr = {a_n, idx_r};
    e_wdata = '0;
    if (cmd.edge_wr) begin
      e_we    = 1'b1;
      e_waddr = {a_n, b_n};
      e_wdata = {1'b1, w_r};
    end else if (cmd.clr_row) begin
      e_we    = 1'b1;
      e_waddr = {a_n, idx_r};
    end else if (cmd.clr_col) begin
      e_we    = 1'b1;
      e_waddr = {idx_r, a_n};
    end else if (cmd.clr_all) begin
      e_we    = 1'b1;
      e_waddr = {row_r, idx_r};
    end
  end
  assign e_raddr = {u_r, idx_r};

  assign stat.op       = op_r;
  assign stat.a_in     = 1'b1;
  assign stat.a_live   = pres_r[a_n];
  assign stat.b_live   = pres_r[b_n];
  assign stat.idx_last = (idx_r == node_t'(MaxNodes - 1));
  assign stat.row_last = (row_r == node_t'(MaxNodes - 1));
  assign stat.found    = found_r;

  // relax candidate with saturation
  logic [DistBits:0] sum;
  dist_t sum_sat;
  logic  relax_hit, scan_hit;
  assign sum     = {1'b0, du_r} + (DistBits + 1)'(e_rdata[WeightBits-1:0]);
  assign sum_sat = sum[DistBits] ? DistMax : sum[DistBits-1:0];

  // read data of both memories belongs to idx_d_r
  assign relax_hit = rd_v_r && e_rdata[WeightBits] && pres_r[idx_d_r] && !vis_r[idx_d_r]
                     && (!reach_r[idx_d_r] || sum_sat < t_rdata);
  assign scan_hit  = sc_v_r && pres_r[idx_d_r] && !vis_r[idx_d_r] && reach_r[idx_d_r]
                     && (!found_r || t_rdata < best_d_r);

  always_comb begin
    t_we    = 1'b0;
    t_waddr = idx_d_r;
    t_wdata = sum_sat;
    if (cmd.q_init) begin
      t_we    = 1'b1;
      t_waddr = a_n;
      t_wdata = '0;
    end else if (relax_hit) begin
      t_we    = 1'b1;
    end
  end
  assign t_raddr = cmd.res_rd ? b_n : idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pres_r  <= '0;
      idx_r   <= '0;
      row_r   <= '0;
      found_r <= 1'b0;
      rd_v_r  <= 1'b0;
      sc_v_r  <= 1'b0;
    end else begin
      rd_v_r <= cmd.relax_rd;
      sc_v_r <= cmd.scan;
      if (cmd.new_graph) begin
        for (int i = 0; i < MaxNodes; i++) begin
          pres_r[i] <= (7'(i) < cnt_r);
        end
      end
      if (cmd.set_pres) pres_r[a_n] <= 1'b1;
      if (cmd.clr_pres) pres_r[a_n] <= 1'b0;
      if (cmd.idx_clr) idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + 1'b1;
      if (cmd.idx_clr && !cmd.row_inc && cmd.load) row_r <= '0;
      else if (cmd.row_inc) row_r <= row_r + 1'b1;
      if (cmd.scan_clr) found_r <= 1'b0;
      else if (scan_hit) found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    idx_d_r <= idx_r;
    if (cmd.load) begin
      op_r  <= op_in;
      a_r   <= node_a_in;
      b_r   <= node_b_in;
      w_r   <= weight_in[WeightBits-1:0];
      cnt_r <= (count_in > 7'(MaxNodes)) ? 7'(MaxNodes) : count_in;
    end
    if (cmd.q_init) begin
      vis_r   <= '0;
      reach_r <= {{(MaxNodes-1){1'b0}}, 1'b1} << a_n;
      u_r     <= a_n;
      du_r    <= '0;
    end
    if (relax_hit) reach_r[idx_d_r] <= 1'b1;
    if (cmd.relax_rd && idx_r == '0) vis_r[u_r] <= 1'b1;
    if (scan_hit) begin
      best_r   <= idx_d_r;
      best_d_r <= t_rdata;
    end
    if (cmd.settle) begin
      u_r  <= best_r;
      du_r <= best_d_r;
    end
    if (cmd.finish) begin
      res_reach <= (op_r == OP_QUERY) && pres_r[a_n] && pres_r[b_n] && reach_r[b_n];
      res_dist  <= ((op_r == OP_QUERY) && pres_r[a_n] && pres_r[b_n] && reach_r[b_n])
                   ? t_rdata : '0;
    end
  end
endmodule
`default_nettype wire

[src/gspe_ctrl.sv]
// Controller state machine: sequences sweeps, relaxation and minimum scans.
// Depends on gspe_pkg.
`default_nettype none
module gspe_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_fire,
  output logic                busy,
  output logic                done,
  input  wire gspe_pkg::stat_t stat,
  output gspe_pkg::cmd_t      cmd
);
  import gspe_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_ROW   = 4'd2;
  localparam logic [3:0] S_COL   = 4'd3;
  localparam logic [3:0] S_ALL   = 4'd4;
  localparam logic [3:0] S_RELAX = 4'd5;
  localparam logic [3:0] S_RLAST = 4'd6;
  localparam logic [3:0] S_SCAN  = 4'd7;
  localparam logic [3:0] S_PICK  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;
  localparam logic [3:0] S_SLAST = 4'd10;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load    = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_DONE;
        unique case (stat.op)
          OP_NEW: begin
            state_nxt = S_ALL;
          end
          OP_CREATE: begin
            cmd.set_pres = 1'b1;
            state_nxt    = S_ROW;
          end
          OP_EDGE: begin
            cmd.edge_wr = stat.a_live && stat.b_live;
          end
          OP_DELETE: begin
            if (stat.a_live) begin
              cmd.clr_pres = 1'b1;
              state_nxt    = S_ROW;
            end
          end
          OP_QUERY: begin
            if (stat.a_live && stat.b_live) begin
              cmd.q_init = 1'b1;
              state_nxt  = S_RELAX;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_ROW: begin
        cmd.clr_row = 1'b1;
        cmd.idx_inc = 1'b1;
        if (stat.idx_last) state_nxt = (stat.op == OP_DELETE) ? S_COL : S_DONE;
      end
      S_COL: begin
        cmd.clr_col = 1'b1;
        cmd.idx_inc = 1'b1;
        if (stat.idx_last) state_nxt = S_DONE;
      end
      S_ALL: begin
        cmd.clr_all = 1'b1;
        cmd.idx_inc = 1'b1;
        if (stat.idx_last) begin
          cmd.row_inc = 1'b1;
          if (stat.row_last) begin
            cmd.new_graph = 1'b1;
            state_nxt     = S_DONE;
          end
        end
      end
      S_RELAX: begin
        // read issued at idx, relax applied in the next cycle
        cmd.relax_rd = 1'b1;
        cmd.idx_inc  = 1'b1;
        if (stat.idx_last) state_nxt = S_RLAST;
      end
      S_RLAST: begin
        cmd.scan_clr = 1'b1;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan    = 1'b1;
        cmd.idx_inc = 1'b1;
        if (stat.idx_last) state_nxt = S_SLAST;
      end
      S_SLAST: begin
        // last compare lands here
        state_nxt = S_PICK;
      end
      S_PICK: begin
        if (stat.found) begin
          cmd.settle = 1'b1;
          state_nxt  = S_RELAX;
        end else begin
          cmd.res_rd = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == S_IDLE) else $error("load outside idle");
  a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> state_r == S_IDLE) else $error("done not followed by idle");
  a_settle_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.settle |-> stat.found) else $error("settle without candidate");
endmodule
`default_nettype wire

[src/graph_shortest_path_engine_core.sv]
// Top level of the shortest path engine: handshake, output register, ctrl and datapath.
// Depends on gspe_pkg, gspe_ctrl, gspe_datapath.
`default_nettype none
// One item at a time. New graph sweeps the 4096-entry edge memory one entry a
// cycle; create and delete sweep a row (and a column); add edge writes one
// entry; a query settles one node at a time, each with an edge read pass
// through the edge memory's one read port followed by a minimum scan.
// The result sits in an output register; the next item is taken once it has
// been transferred out.
module graph_shortest_path_engine_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [2:0] operation, [8:3] node_a, [14:9] node_b, [30:15] edge_weight_in,
  // [37:31] node_count, [39:38] zero
  input  wire logic [39:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [21:0] distance, [22] reachable, [23] zero
  output logic [23:0]      out_tdata
);
  import gspe_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  busy, done, in_fire;
  dist_t res_dist;
  logic  res_reach;
  logic  ovalid_r;

  assign in_tready = !busy && !ovalid_r;
  assign in_fire   = in_tvalid && in_tready;

  gspe_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .busy(busy), .done(done),
    .stat(stat), .cmd(cmd)
  );

  gspe_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .op_in(in_tdata[2:0]), .node_a_in(in_tdata[8:3]), .node_b_in(in_tdata[14:9]),
    .weight_in(in_tdata[30:15]), .count_in(in_tdata[37:31]),
    .res_dist(res_dist), .res_reach(res_reach)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (done) ovalid_r <= 1'b1;
    else if (out_tready) ovalid_r <= 1'b0;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {1'b0, res_reach, res_dist};

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> busy) else $error("accepted item not started");
  a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !ovalid_r) else $error("result overwrite");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !out_tready |=> ovalid_r) else $error("result dropped");
endmodule
`default_nettype wire

[sim/tb.sv]
// Testbench for graph_shortest_path_engine_core: directed and random graph edits and distance queries.
// Predicts every result with its own graph copy; depends on gspe_pkg and the core RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import gspe_pkg::*;

  localparam int CycleLimit = 8000000;

  typedef struct packed {
    logic [6:0]  node_count;
    logic [15:0] weight;
    logic [5:0]  node_b;
    logic [5:0]  node_a;
    logic [2:0]  op;
  } cmd_item_t;

  typedef struct packed {
    logic        reachable;
    logic [21:0] distance;
  } path_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;

  graph_shortest_path_engine_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // graph copy for prediction
  bit          present [MaxNodes];
  bit          link_ok [MaxNodes][MaxNodes];
  logic [15:0] link_w  [MaxNodes][MaxNodes];

  cmd_item_t pending_cmds[$];
  path_res_t expected_paths[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit drain_hold = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;

  initial forever #2 clk = ~clk;

  function automatic path_res_t shortest_path(logic [5:0] src, logic [5:0] dst);
    logic [21:0] plen [MaxNodes];
    bit seen [MaxNodes];
    bit done [MaxNodes];
    logic [22:0] sum;
    int u;
    int best;
    path_res_t r;
    r = '0;
    if (!present[src] || !present[dst]) return r;
    foreach (plen[i]) begin
      plen[i] = '0; seen[i] = 0; done[i] = 0;
    end
    seen[src] = 1;
    u = src;
    forever begin
      done[u] = 1;
      for (int i = 0; i < MaxNodes; i++) begin
        if (!link_ok[u][i] || !present[i] || done[i]) continue;
        sum = plen[u] + link_w[u][i];
        if (sum > DistMax) sum = {1'b0, DistMax};
        if (!seen[i] || sum < plen[i]) begin
          plen[i] = sum[21:0]; seen[i] = 1;
        end
      end
      best = -1;
      for (int i = 0; i < MaxNodes; i++) begin
        if (!present[i] || done[i] || !seen[i]) continue;
        if (best < 0 || plen[i] < plen[best]) best = i;
      end
      if (best < 0) break;
      u = best;
    end
    r.reachable = seen[dst];
    r.distance = seen[dst] ? plen[dst] : '0;
    return r;
  endfunction

  function automatic path_res_t apply_cmd(cmd_item_t c);
    path_res_t r;
    int n;
    r = '0;
    case (c.op)
      OP_NEW: begin
        n = (c.node_count > MaxNodes) ? MaxNodes : c.node_count;
        for (int i = 0; i < MaxNodes; i++) begin
          present[i] = (i < n);
          for (int j = 0; j < MaxNodes; j++) link_ok[i][j] = 0;
        end
      end
      OP_CREATE: begin
        present[c.node_a] = 1;
        for (int j = 0; j < MaxNodes; j++) link_ok[c.node_a][j] = 0;
      end
      OP_EDGE: if (present[c.node_a] && present[c.node_b]) begin
        link_ok[c.node_a][c.node_b] = 1;
        link_w[c.node_a][c.node_b] = c.weight;
      end
      OP_DELETE: if (present[c.node_a]) begin
        present[c.node_a] = 0;
        for (int j = 0; j < MaxNodes; j++) begin
          link_ok[c.node_a][j] = 0; link_ok[j][c.node_a] = 0;
        end
      end
      OP_QUERY: r = shortest_path(c.node_a, c.node_b);
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  function automatic cmd_item_t mk(logic [2:0] op, logic [5:0] a, logic [5:0] b,
                                   logic [15:0] w, logic [6:0] n);
    cmd_item_t c;
    c.op = op; c.node_a = a; c.node_b = b; c.weight = w; c.node_count = n;
    return c;
  endfunction

  // random item biased toward a small live graph
  function automatic cmd_item_t rand_cmd(int span);
    cmd_item_t c;
    logic [63:0] raw;
    int k;
    raw = {$urandom, $urandom};
    c = raw[37:0];
    k = $urandom_range(0, 99);
    c.node_a = 6'($urandom_range(0, span - 1));
    c.node_b = 6'($urandom_range(0, span - 1));
    if (k < 3) c.op = OP_NEW;
    else if (k < 10) c.op = OP_CREATE;
    else if (k < 50) c.op = OP_EDGE;
    else if (k < 56) c.op = OP_DELETE;
    else if (k < 94) c.op = OP_QUERY;
    else c.op = 3'($urandom_range(5, 7));
    if (c.op == OP_NEW) c.node_count = $urandom_range(0, 3) == 0
                                       ? 7'($urandom_range(0, 127))
                                       : 7'($urandom_range(2, span));
    if ($urandom_range(0, 3) == 0) c.weight = 16'($urandom_range(0, 15));
    if ($urandom_range(0, 9) == 0) c.node_a = 6'($urandom_range(0, 63));
    return c;
  endfunction

  initial begin
    // directed part: extremes, every operation, absent ends
    pending_cmds.push_back(mk(OP_QUERY, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_NEW, 0, 0, 0, 7'd100));
    pending_cmds.push_back(mk(OP_EDGE, 63, 0, 16'hFFFF, 0));
    pending_cmds.push_back(mk(OP_QUERY, 63, 63, 0, 0));
    pending_cmds.push_back(mk(OP_NEW, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_QUERY, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_DELETE, 5, 0, 0, 0));
    pending_cmds.push_back(mk(OP_CREATE, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_CREATE, 63, 0, 0, 0));
    pending_cmds.push_back(mk(OP_EDGE, 0, 1, 9, 0));
    pending_cmds.push_back(mk(OP_EDGE, 0, 63, 16'hFFFF, 0));
    pending_cmds.push_back(mk(OP_EDGE, 0, 63, 16'hFFFE, 0));
    pending_cmds.push_back(mk(OP_EDGE, 63, 0, 0, 0));
    pending_cmds.push_back(mk(OP_QUERY, 0, 63, 0, 0));
    pending_cmds.push_back(mk(OP_QUERY, 63, 0, 0, 0));
    pending_cmds.push_back(mk(OP_QUERY, 0, 1, 0, 0));
    pending_cmds.push_back(mk(3'd7, 63, 63, 16'hFFFF, 7'h7F));
    pending_cmds.push_back(mk(3'd5, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_NEW, 0, 0, 0, 7'd64));
    for (int i = 0; i < 64; i++)
      pending_cmds.push_back(mk(OP_EDGE, 6'(i), 6'((i + 1) % 64), 16'hFFFF, 0));
    pending_cmds.push_back(mk(OP_QUERY, 0, 63, 0, 0));
    pending_cmds.push_back(mk(OP_DELETE, 63, 0, 0, 0));
    pending_cmds.push_back(mk(OP_QUERY, 62, 0, 0, 0));
    pending_cmds.push_back(mk(OP_NEW, 0, 0, 0, 7'd8));
    for (int i = 0; i < 53; i++)
      pending_cmds.push_back(rand_cmd(i < 38 ? 8 : 16));
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_paths.push_back(apply_cmd(in_tdata[37:0]));
        in_tvalid <= 1'b0;
        if (pending_cmds.size() == 100 && !drain_hold) drain_hold <= 1'b1;
      end else if (!in_tvalid) begin
        if (drain_hold) begin
          if (expected_paths.size() == 0) drain_hold <= 1'b0;
        end else if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_cmds.size() > 0) begin
          in_tdata <= {2'b00, pending_cmds.pop_front()};
          in_tvalid <= 1'b1;
          if (!calm && $urandom_range(0, 2) == 0) send_gap <= $urandom_range(1, 12);
        end
      end
      if (pending_cmds.size() < 20) calm <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    path_res_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = path_res_t'(out_tdata[22:0]);
        if (out_tdata[23] !== 1'b0) report("pad bit set");
        if (expected_paths.size() == 0) begin
          report("result with nothing expected");
        end else begin
          want = expected_paths.pop_front();
          if (got.distance !== want.distance)
            report($sformatf("distance %0d want %0d", got.distance, want.distance));
          if (got.reachable !== want.reachable)
            report($sformatf("reachable %0b want %0b", got.reachable, want.reachable));
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        recv_gap <= $urandom_range(1, 12);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int tail;
    tail = 0;
    while (cycles < CycleLimit && tail < 20000) begin
      @(posedge clk);
      cycles++;
      if (rst_n && pending_cmds.size() == 0 && !in_tvalid && expected_paths.size() == 0)
        tail++;
    end
    if (cycles >= CycleLimit) begin
      $display("FAIL graph_shortest_path_engine_core");
    end else if (errors == 0 && !out_tvalid) begin
      $display("PASS graph_shortest_path_engine_core");
    end else begin
      $display("FAIL graph_shortest_path_engine_core");
    end
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
src/gspe_pkg.sv
src/gspe_ram.sv
src/gspe_datapath.sv
src/gspe_ctrl.sv
src/graph_shortest_path_engine_core.sv
sim/tb.sv
